// ===== rtl/bfa_pkg.sv =====
// Shared types and codes for the best-fit block allocator.
// No dependencies; imported by the top level.
`default_nettype none

package bfa_pkg;

	localparam int MAX_BLOCKS_DEF = 64;
	localparam int ADDR_BITS_DEF  = 32;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_START   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_END     = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES = 2'd2;

	localparam logic [31:0] HEAP_START_RST   = 32'h0000_0000;
	localparam logic [31:0] HEAP_END_RST     = 32'hFFFF_FFFF;
	localparam logic [7:0]  HEADER_BYTES_RST = 8'd24;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO     = 2'd1;
	localparam logic [1:0] ST_NO_SPACE = 2'd2;
	localparam logic [1:0] ST_UNKNOWN  = 2'd3;

	typedef struct packed {
		logic        command;
		logic [31:0] request_size;
		logic [31:0] release_address;
	} req_item_t;

	typedef struct packed {
		logic [31:0] region_address;
		logic [31:0] granted_size;
		logic        reused;
		logic [1:0]  status;
	} rsp_item_t;

	typedef struct packed {
		logic [31:0] base;
		logic [31:0] size;
		logic        free;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/bfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/best_fit_block_allocator.sv =====
// From accept to result valid, a reuse, free or full table runs SCAN, DRAIN, DECIDE, FINISH;
// an append adds APPEND1 and APPEND2 before FINISH, an empty table skips SCAN and DRAIN, and a
// zero-size or null item goes straight to FINISH. The next item is taken the cycle after its
// result is registered, so items never overlap; a held result stalls the next one.
// Reset: heap_end all ones, header_bytes 24, table empty, break at heap_start 0;
// the table RAM, scanned one entry per cycle, is not cleared. Depends on bfa_pkg and bfa_ram.
`default_nettype none

module best_fit_block_allocator #(
	parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF,
	parameter int ADDR_BITS  = bfa_pkg::ADDR_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire bfa_pkg::req_item_t                 req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output bfa_pkg::rsp_item_t                      rsp,
	input  wire logic                               cfg_wr_en,
	input  wire logic [bfa_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [bfa_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import bfa_pkg::*;

	localparam int IW   = $clog2(MAX_BLOCKS);
	localparam int CNTW = $clog2(MAX_BLOCKS + 1);
	localparam int CW   = (ADDR_BITS > 33) ? ADDR_BITS + 1 : 34;
	localparam logic [CW-1:0] ADDR_MASK_C = {{(CW-ADDR_BITS){1'b0}}, {ADDR_BITS{1'b1}}};
	localparam int EW   = $bits(entry_t);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_SCAN    = 3'd1;
	localparam logic [2:0] S_DRAIN   = 3'd2;
	localparam logic [2:0] S_DECIDE  = 3'd3;
	localparam logic [2:0] S_APPEND1 = 3'd4;
	localparam logic [2:0] S_APPEND2 = 3'd5;
	localparam logic [2:0] S_FINISH  = 3'd6;

	logic [2:0]           state_q;
	logic [IW-1:0]        scan_q;
	logic                 rd_pending_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic                 found_q;
	logic [IW-1:0]        best_idx_q;
	logic [31:0]          best_base_q;
	logic [31:0]          best_size_q;
	logic                 cmd_q;
	logic [31:0]          size_q;
	logic [31:0]          addr_q;
	logic [32:0]          need_q;
	logic [CW-1:0]        sum_q;
	rsp_item_t            res_q;
	rsp_item_t            rsp_q;
	logic                 rsp_valid_q;
	logic [31:0]          heap_end_q;
	logic [7:0]           header_q;
	logic [ADDR_BITS-1:0] bp_q;
	logic [CNTW-1:0]      count_q;

	logic                 ram_we;
	logic [IW-1:0]        ram_waddr;
	entry_t               ram_wdata;
	logic [EW-1:0]        ram_rdata;
	entry_t               rd_entry;

	logic                 accept;
	logic                 rsp_load;
	logic                 take;
	logic [IW-1:0]        last_idx;
	logic                 table_full;
	logic [CW-1:0]        bp_ext;
	logic [CW-1:0]        heap_end_ext;
	logic [CW-1:0]        region_full;
	logic [31:0]          region32;
	logic                 append_fail;

	bfa_ram #(
		.WIDTH (EW),
		.DEPTH (MAX_BLOCKS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_q),
		.rdata (ram_rdata)
	);

	assign rd_entry     = entry_t'(ram_rdata);
	assign req_ready    = (state_q == S_IDLE);
	assign accept       = req_valid && req_ready;
	assign rsp_load     = (state_q == S_FINISH) && (!rsp_valid_q || rsp_ready);
	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;
	assign last_idx     = IW'(count_q - CNTW'(1));
	assign table_full   = (count_q == CNTW'(MAX_BLOCKS));
	assign bp_ext       = CW'(bp_q);
	assign heap_end_ext = CW'(heap_end_q);
	assign region_full  = bp_ext + CW'(header_q);
	assign region32     = 32'(region_full & ADDR_MASK_C);
	assign append_fail  = (bp_ext > heap_end_ext) || (sum_q > heap_end_ext);

	always_comb begin
		if (cmd_q == CMD_FREE) begin
			take = rd_pending_s1 && !found_q && (rd_entry.base == addr_q);
		end else begin
			take = rd_pending_s1 && rd_entry.free && (rd_entry.size >= size_q) &&
				(!found_q || (rd_entry.size < best_size_q));
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = best_idx_q;
		ram_wdata = '{base: best_base_q, size: best_size_q, free: cmd_q == CMD_FREE};
		if (state_q == S_DECIDE) begin
			ram_we = found_q;
		end else if (state_q == S_APPEND2) begin
			ram_we    = !append_fail;
			ram_waddr = count_q[IW-1:0];
			ram_wdata = '{base: region32, size: size_q, free: 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			scan_q        <= '0;
			rd_pending_s1 <= 1'b0;
			found_q       <= 1'b0;
			rsp_valid_q   <= 1'b0;
			heap_end_q    <= HEAP_END_RST;
			header_q      <= HEADER_BYTES_RST;
			bp_q          <= ADDR_BITS'(CW'(HEAP_START_RST));
			count_q       <= '0;
		end else begin
			rd_pending_s1 <= (state_q == S_SCAN);
			if (take) begin
				found_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_HEAP_START: begin
						if (count_q == '0) begin
							bp_q <= ADDR_BITS'(CW'(cfg_data));
						end
					end
					CFG_HEAP_END:     heap_end_q <= cfg_data;
					CFG_HEADER_BYTES: header_q   <= cfg_data[7:0];
					default: ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						scan_q  <= '0;
						if (req.command == CMD_ALLOC && req.request_size == '0) begin
							state_q <= S_FINISH;
						end else if (req.command == CMD_FREE && req.release_address == '0) begin
							state_q <= S_FINISH;
						end else if (count_q == '0) begin
							state_q <= S_DECIDE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_q == last_idx) begin
						state_q <= S_DRAIN;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				S_DRAIN: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (cmd_q == CMD_FREE || found_q || table_full) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_APPEND1;
					end
				end
				S_APPEND1: state_q <= S_APPEND2;
				S_APPEND2: begin
					if (!append_fail) begin
						count_q <= count_q + CNTW'(1);
						bp_q    <= sum_q[ADDR_BITS-1:0];
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_q;
		if (take) begin
			best_idx_q  <= rd_idx_s1;
			best_base_q <= rd_entry.base;
			best_size_q <= rd_entry.size;
		end
		if (rsp_load) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				cmd_q  <= req.command;
				size_q <= req.request_size;
				addr_q <= req.release_address;
				need_q <= 33'(header_q) + 33'(req.request_size);
				res_q  <= '{region_address: '0, granted_size: '0, reused: 1'b0,
					status: (req.command == CMD_ALLOC && req.request_size == '0) ?
						ST_ZERO : ST_OK};
			end
			S_DECIDE: begin
				if (cmd_q == CMD_FREE) begin
					res_q <= '{region_address: '0, granted_size: '0, reused: 1'b0,
						status: found_q ? ST_OK : ST_UNKNOWN};
				end else if (found_q) begin
					res_q <= '{region_address: best_base_q, granted_size: best_size_q,
						reused: 1'b1, status: ST_OK};
				end else begin
					res_q <= '{region_address: '0, granted_size: '0, reused: 1'b0,
						status: table_full ? ST_NO_SPACE : ST_OK};
				end
			end
			S_APPEND1: sum_q <= bp_ext + CW'(need_q);
			S_APPEND2: begin
				if (append_fail) begin
					res_q <= '{region_address: '0, granted_size: '0, reused: 1'b0,
						status: ST_NO_SPACE};
				end else begin
					res_q <= '{region_address: region32, granted_size: size_q, reused: 1'b0,
						status: ST_OK};
				end
			end
			default: ;
		endcase
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_BLOCKS))
		else $error("entry count beyond table capacity");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req_ready)
		else $error("ready held after an item was taken");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_DECIDE || state_q == S_APPEND2))
		else $error("table written outside an update step");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNTW'(1)))
		else $error("entry count moved by more than one");

	a_reuse_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.reused) |-> (rsp.status == ST_OK))
		else $error("reused block reported with error status");

endmodule

`default_nettype wire
